/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the decimal number parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DNP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Check that an antecedent implies a consequent in the same cycle.
`define DNP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`endif

/* rtl/dnp_pkg.sv */
// Package with constants and types of the decimal number parser.
`default_nettype none

package dnp_pkg;

    localparam int MANT_W = 27;
    localparam int EXP_W  = 8;
    localparam int DCNT_W = 4;
    localparam int CHR_W  = 8;

    localparam int DEF_MAX_DIGITS = 8;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;

    localparam logic signed [EXP_W-1:0] EXP_MAX   = 8'sd127;
    localparam logic [DCNT_W-1:0]       COUNT_SAT = 4'd9;
    localparam logic [CHR_W-1:0]        CHARS_SAT = 8'd255;

    typedef struct packed {
        logic                       valid_res;
        logic                       negative;
        logic [MANT_W-1:0]          mantissa;
        logic signed [EXP_W-1:0]    dec_exponent;
        logic [CHR_W-1:0]           consumed;
    } t_result;

endpackage

`default_nettype wire

/* rtl/dnp_core.sv */
// Parse state registers and per-character update of the decimal number parser.
`default_nettype none

module dnp_core #(
    parameter int MAX_DIGITS = dnp_pkg::DEF_MAX_DIGITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_start_req,
    output logic                  o_emit,
    output dnp_pkg::t_result      o_res
);
    import dnp_pkg::*;

    logic                     r_active, n_active;
    logic                     r_expect, n_expect;
    logic                     r_neg, n_neg;
    logic                     r_point, n_point;
    logic [MANT_W-1:0]        r_acc, n_acc;
    logic signed [EXP_W-1:0]  r_exp, n_exp;
    logic [DCNT_W-1:0]        r_dcnt, n_dcnt;
    logic [CHR_W-1:0]         r_ccnt, n_ccnt;

    logic                     e_active, e_expect, e_neg, e_point;
    logic [MANT_W-1:0]        e_acc;
    logic signed [EXP_W-1:0]  e_exp;
    logic [DCNT_W-1:0]        e_dcnt;
    logic [CHR_W-1:0]         e_ccnt;
    logic [CHR_W-1:0]         ccnt_bump;
    logic                     is_sign, is_digit, is_point, valid;
    logic [3:0]               digit;

    assign is_sign  = (i_ch == CH_MINUS) || (i_ch == CH_PLUS);
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_point = (i_ch == CH_POINT);
    assign digit    = 4'(i_ch - CH_ZERO);

    always_comb begin
        e_active = r_active || i_start_req;
        e_expect = i_start_req ? 1'b1 : r_expect;
        e_neg    = i_start_req ? 1'b0 : r_neg;
        e_point  = i_start_req ? 1'b0 : r_point;
        e_acc    = i_start_req ? '0 : r_acc;
        e_exp    = i_start_req ? '0 : r_exp;
        e_dcnt   = i_start_req ? '0 : r_dcnt;
        e_ccnt   = i_start_req ? '0 : r_ccnt;
        ccnt_bump = (e_ccnt < CHARS_SAT) ? e_ccnt + 8'd1 : e_ccnt;
        valid    = (e_dcnt != '0);
    end

    always_comb begin
        n_active = r_active;
        n_expect = r_expect;
        n_neg    = r_neg;
        n_point  = r_point;
        n_acc    = r_acc;
        n_exp    = r_exp;
        n_dcnt   = r_dcnt;
        n_ccnt   = r_ccnt;
        o_emit   = 1'b0;
        o_res.valid_res    = valid;
        o_res.negative     = valid && e_neg;
        o_res.mantissa     = valid ? e_acc : '0;
        o_res.dec_exponent = valid ? e_exp : '0;
        o_res.consumed     = valid ? e_ccnt : '0;
        if (i_en && e_active) begin
            n_active = 1'b1;
            n_expect = 1'b0;
            n_neg    = e_neg;
            n_point  = e_point;
            n_acc    = e_acc;
            n_exp    = e_exp;
            n_dcnt   = e_dcnt;
            n_ccnt   = ccnt_bump;
            if (e_expect && is_sign) begin
                n_neg = (i_ch == CH_MINUS);
            end else if (is_digit) begin
                if (e_dcnt < DCNT_W'(MAX_DIGITS)) begin
                    n_dcnt = e_dcnt + 4'd1;
                    n_acc  = (e_acc << 3) + (e_acc << 1) + MANT_W'(digit);
                    if (e_point) begin
                        n_exp = e_exp - 8'sd1;
                    end
                end else begin
                    if (e_dcnt < COUNT_SAT) begin
                        n_dcnt = e_dcnt + 4'd1;
                    end
                    if (!e_point && (e_exp < EXP_MAX)) begin
                        n_exp = e_exp + 8'sd1;
                    end
                end
            end else if (is_point && !e_point) begin
                n_point = 1'b1;
            end else begin
                o_emit   = 1'b1;
                n_active = 1'b0;
                n_neg    = 1'b0;
                n_point  = 1'b0;
                n_acc    = '0;
                n_exp    = '0;
                n_dcnt   = '0;
                n_ccnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_expect <= 1'b0;
            r_neg    <= 1'b0;
            r_point  <= 1'b0;
            r_acc    <= '0;
            r_exp    <= '0;
            r_dcnt   <= '0;
            r_ccnt   <= '0;
        end else begin
            r_active <= n_active;
            r_expect <= n_expect;
            r_neg    <= n_neg;
            r_point  <= n_point;
            r_acc    <= n_acc;
            r_exp    <= n_exp;
            r_dcnt   <= n_dcnt;
            r_ccnt   <= n_ccnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/decimal_number_parser.sv */
// Top level of the decimal number parser: parse core, result register and skid stage.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | request   | i_in_valid / o_in_ready  | i_ch, i_start_req
//  out     | result    | o_out_valid / i_out_ready| o_valid_res, o_negative, o_mantissa,
//          |           |                          | o_dec_exponent, o_consumed
//
// One character per cycle while o_in_ready is high; the parse state updates in the cycle a request is accepted.
// A result is registered from its terminating character; the output register takes it unless stalled.
// A stalled result waits in the output register; one more result fits in the skid stage.
// o_in_ready drops only while the skid stage is full.
// Reset is synchronous, active low, and clears the parse state and empties both result slots.
`default_nettype none
`include "assert_macros.svh"

module decimal_number_parser #(
    parameter int MAX_DIGITS = dnp_pkg::DEF_MAX_DIGITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [7:0]                              i_ch,
    input  wire logic                                    i_start_req,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic                                         o_valid_res,
    output logic                                         o_negative,
    output logic [dnp_pkg::MANT_W-1:0]                   o_mantissa,
    output logic signed [dnp_pkg::EXP_W-1:0]             o_dec_exponent,
    output logic [dnp_pkg::CHR_W-1:0]                    o_consumed
);
    import dnp_pkg::*;

    logic    take, emit, out_fire;
    t_result res;
    t_result r_out, r_skid;
    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    logic    out_fields_zero, out_fields_sane;

    assign o_in_ready = !r_skid_v;
    assign take       = i_in_valid && o_in_ready;
    assign out_fire   = r_out_v && i_out_ready;

    dnp_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (take),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .o_emit      (emit),
        .o_res       (res)
    );

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (!r_out_v || out_fire) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = emit;
            end
        end else if (emit) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || out_fire) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (emit) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_valid_res    = r_out.valid_res;
    assign o_negative     = r_out.negative;
    assign o_mantissa     = r_out.mantissa;
    assign o_dec_exponent = r_out.dec_exponent;
    assign o_consumed     = r_out.consumed;

    assign out_fields_zero = !o_negative && (o_mantissa == '0) && (o_dec_exponent == '0)
                             && (o_consumed == '0);
    assign out_fields_sane = (o_consumed != '0)
                             && (o_dec_exponent >= -EXP_W'(MAX_DIGITS));

    `DNP_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `DNP_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_valid_res, out_fields_zero)
    `DNP_ASSERT_IMPLY(a_valid_consumed, i_clk, i_rst_n, o_out_valid && o_valid_res, out_fields_sane)

endmodule

`default_nettype wire

/* sim/parse_checker.sv */
`timescale 1ns / 1ps
// Checker for the decimal number parser: watches both channels, predicts each result, compares.
module parse_checker #(
    parameter int MAX_DIGITS = dnp_pkg::DEF_MAX_DIGITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [7:0]                       i_ch,
    input  logic                             i_start_req,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_valid_res,
    input  logic                             i_negative,
    input  logic [dnp_pkg::MANT_W-1:0]       i_mantissa,
    input  logic signed [dnp_pkg::EXP_W-1:0] i_dec_exponent,
    input  logic [dnp_pkg::CHR_W-1:0]        i_consumed,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_results
);
    import dnp_pkg::*;

    logic                    num_active;
    logic                    want_sign;
    logic                    minus_seen;
    logic                    point_seen;
    logic [MANT_W-1:0]       mant_acc;
    logic signed [EXP_W-1:0] expo_acc;
    logic [DCNT_W-1:0]       ndigits;
    logic [CHR_W-1:0]        nchars;

    t_result expected_numbers[$];

    function automatic void clear_number();
        want_sign  = 1'b0;
        minus_seen = 1'b0;
        point_seen = 1'b0;
        mant_acc   = '0;
        expo_acc   = '0;
        ndigits    = '0;
        nchars     = '0;
    endfunction

    function automatic void count_char();
        if (nchars != CHARS_SAT) begin
            nchars++;
        end
    endfunction

    // Advance the parse state by one character; return 1 when it ends a number.
    function automatic bit parse_char(input logic [7:0] c, input logic s, output t_result r);
        logic [3:0] d;
        r = '0;
        if (s) begin
            clear_number();
            num_active = 1'b1;
            want_sign  = 1'b1;
        end
        if (!num_active) begin
            return 1'b0;
        end
        if (want_sign) begin
            want_sign = 1'b0;
            if (c == CH_MINUS || c == CH_PLUS) begin
                if (c == CH_MINUS) begin
                    minus_seen = 1'b1;
                end
                count_char();
                return 1'b0;
            end
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 4'(c - CH_ZERO);
            if (ndigits < MAX_DIGITS) begin
                ndigits++;
                if (point_seen) begin
                    expo_acc--;
                end
                mant_acc = mant_acc * 10 + d;
            end else begin
                if (ndigits < COUNT_SAT) begin
                    ndigits++;
                end
                if (!point_seen && expo_acc < EXP_MAX) begin
                    expo_acc++;
                end
            end
            count_char();
            return 1'b0;
        end
        if (c == CH_POINT && !point_seen) begin
            point_seen = 1'b1;
            count_char();
            return 1'b0;
        end
        if (ndigits != 0) begin
            r.valid_res    = 1'b1;
            r.negative     = minus_seen;
            r.mantissa     = mant_acc;
            r.dec_exponent = expo_acc;
            r.consumed     = nchars;
        end
        num_active = 1'b0;
        clear_number();
        return 1'b1;
    endfunction

    function automatic int field_diff(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result pred;
        t_result want;
        int      bad;
        if (!i_rst_n) begin
            num_active = 1'b0;
            clear_number();
            expected_numbers.delete();
            o_fail_count = 0;
            o_results    = 0;
        end else begin
            // Check the outgoing result first: it belongs to an older request.
            if (i_out_valid && i_out_ready) begin
                if (expected_numbers.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual mantissa %0d",
                             $time, i_mantissa);
                    o_fail_count++;
                end else begin
                    want = expected_numbers.pop_front();
                    bad  = field_diff("valid_res", want.valid_res, i_valid_res)
                         + field_diff("negative", want.negative, i_negative)
                         + field_diff("mantissa", want.mantissa, i_mantissa)
                         + field_diff("dec_exponent", $signed(want.dec_exponent),
                                      i_dec_exponent)
                         + field_diff("consumed", want.consumed, i_consumed);
                    if (bad != 0) begin
                        o_fail_count++;
                    end
                    o_results++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_char(i_ch, i_start_req, pred)) begin
                    expected_numbers.push_back(pred);
                end
            end
        end
        o_pending = expected_numbers.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the decimal number parser testbench: clock, reset, character requests and verdict.
module testbench;
    import dnp_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int N_PHASES    = 4;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [7:0]              in_ch     = 8'h00;
    logic                    in_start  = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    res_valid;
    logic                    res_negative;
    logic [MANT_W-1:0]       res_mantissa;
    logic signed [EXP_W-1:0] res_exponent;
    logic [CHR_W-1:0]        res_consumed;

    int fail_count;
    int pending;
    int results;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int numbers_sent   = 0;

    int idle_table[N_PHASES]  = '{0, 85, 0, 32};
    int stall_table[N_PHASES] = '{0, 0, 85, 32};

    decimal_number_parser DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_ch           (in_ch),
        .i_start_req    (in_start),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_valid_res    (res_valid),
        .o_negative     (res_negative),
        .o_mantissa     (res_mantissa),
        .o_dec_exponent (res_exponent),
        .o_consumed     (res_consumed)
    );

    parse_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_ch           (in_ch),
        .i_start_req    (in_start),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_valid_res    (res_valid),
        .i_negative     (res_negative),
        .i_mantissa     (res_mantissa),
        .i_dec_exponent (res_exponent),
        .i_consumed     (res_consumed),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (results)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(input logic [7:0] c, input logic s, input bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ch    <= c;
        in_start <= s;
        do @(posedge clk); while (!in_ready);
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == 0, 1'b1);
        end
    endtask

    // Build one number string: optional junk, optional sign, digits, optional point and fraction, terminator.
    task automatic send_number(input bit long_run, input bit finish);
        logic [7:0] text[$];
        logic [7:0] c;
        int         n_int;
        int         n_frac;
        int         sel;
        bit         has_point;
        if ($urandom_range(15) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
        end
        case ($urandom_range(2))
            0: ;
            1: text.push_back(CH_MINUS);
            default: text.push_back(CH_PLUS);
        endcase
        n_int = long_run ? $urandom_range(130, 300) : $urandom_range(0, 12);
        repeat (n_int) begin
            text.push_back(8'(CH_ZERO + (($urandom_range(3) == 0) ? 0 : $urandom_range(9))));
        end
        has_point = $urandom_range(1);
        if (has_point) begin
            text.push_back(CH_POINT);
            n_frac = $urandom_range(0, 12);
            repeat (n_frac) begin
                text.push_back(8'(CH_ZERO + (($urandom_range(3) == 0) ? 0 : $urandom_range(9))));
            end
        end
        sel = $urandom_range(7);
        if (sel == 0) begin
            c = $urandom_range(1) ? CH_MINUS : CH_PLUS;
        end else if (sel == 1 && has_point) begin
            c = CH_POINT;
        end else begin
            do c = 8'($urandom_range(255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT ||
                   c == CH_MINUS || c == CH_PLUS);
        end
        text.push_back(c);
        // Drop the tail now and then so the next start cuts the number short.
        if (!finish && text.size() > 1 && $urandom_range(11) == 0) begin
            text = text[0:$urandom_range(text.size() - 2)];
        end
        foreach (text[i]) begin
            send_char(text[i], i == 0, 1'b1);
        end
        numbers_sent++;
    endtask

    initial begin
        bit first_long;
        first_long = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_str("-9.5x");
        send_str("+0/");
        send_char(8'hFF, 1'b1, 1'b1);
        send_char(CH_POINT, 1'b1, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);
        send_str("-:");
        send_str("1.2.");
        send_str("7-");
        send_char("5", 1'b0, 1'b0);
        send_str("12");
        send_str("3 ");

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct  = idle_table[ph];
            recv_stall_pct = stall_table[ph];
            while (items_sent < (ph + 1) * ITEM_TARGET / N_PHASES) begin
                send_number(first_long || $urandom_range(29) == 0, 1'b0);
                first_long = 1'b0;
            end
        end
        send_number(1'b0, 1'b1);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d characters in %0d number strings over %0d handshake phases.",
                 items_sent, numbers_sent, N_PHASES);
        $display("Compared %0d parse results; %0d failed.", results, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dnp_pkg.sv
rtl/dnp_core.sv
rtl/decimal_number_parser.sv
sim/parse_checker.sv
sim/testbench.sv
